FILE: rtl/core/mld_pkg.sv
// Package: shared constants, beat types and helpers of the mouse look direction block
`default_nettype none

package mld_pkg;

    localparam int ANGLE_FRACTION_BITS = 8;
    localparam int TRIG_ITERATIONS     = 16;
    localparam int WORK_FRAC           = 24;

    localparam int YAW_W       = 9 + ANGLE_FRACTION_BITS;
    localparam int PITCH_W     = 8 + ANGLE_FRACTION_BITS;
    localparam int DELTA_SHIFT = 16 - ANGLE_FRACTION_BITS;
    localparam int DELTA_W     = 34 - DELTA_SHIFT;
    localparam int MOD_W       = 19 + ANGLE_FRACTION_BITS;
    localparam int MOD_STEPS   = 10;
    localparam int MOD_CNT_W   = 4;
    localparam int CORDIC_W    = 34;
    localparam int TRIG_W      = 32;
    localparam int ITER_W      = 5;

    localparam logic [MOD_W-1:0] ANGLE_FULL   = MOD_W'(360 << ANGLE_FRACTION_BITS);
    localparam logic [MOD_W-1:0] ANGLE_HALF   = MOD_W'(180 << ANGLE_FRACTION_BITS);
    localparam logic [MOD_W-1:0] ANGLE_OFFSET = MOD_W'((360 << ANGLE_FRACTION_BITS)
                                                       << (MOD_STEPS - 1));

    localparam logic signed [YAW_W-1:0]   YAW_RESET   = YAW_W'(-(90 << ANGLE_FRACTION_BITS));
    localparam logic signed [PITCH_W-1:0] PITCH_RESET = PITCH_W'(45 << ANGLE_FRACTION_BITS);
    localparam logic signed [PITCH_W-1:0] PITCH_LIMIT = PITCH_W'(89 << ANGLE_FRACTION_BITS);
    localparam logic [15:0]               SENS_RESET  = 16'd6554;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN    = CORDIC_W'(652032875);
    localparam logic signed [CORDIC_W-1:0] CORDIC_QUARTER = CORDIC_W'(64'sd90 <<< WORK_FRAC);
    localparam logic signed [CORDIC_W-1:0] CORDIC_HALF    = CORDIC_W'(64'sd180 <<< WORK_FRAC);

    typedef struct packed {
        logic signed [15:0] cursor_x;
        logic signed [15:0] cursor_y;
    } t_cursor;

    typedef struct packed {
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic               pitch_limited;
    } t_front;

    typedef struct packed {
        logic                       done;
        logic signed [CORDIC_W-1:0] cos_val;
        logic signed [CORDIC_W-1:0] sin_val;
    } t_trig;

    // arctangent of 2^-idx in degrees, Q.24
    function automatic logic signed [CORDIC_W-1:0] atan_q24(input logic [ITER_W-1:0] idx);
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            5'd0:    v = CORDIC_W'(754974720);
            5'd1:    v = CORDIC_W'(445687602);
            5'd2:    v = CORDIC_W'(235489089);
            5'd3:    v = CORDIC_W'(119537938);
            5'd4:    v = CORDIC_W'(60000934);
            5'd5:    v = CORDIC_W'(30029717);
            5'd6:    v = CORDIC_W'(15018523);
            5'd7:    v = CORDIC_W'(7509720);
            5'd8:    v = CORDIC_W'(3754917);
            5'd9:    v = CORDIC_W'(1877466);
            5'd10:   v = CORDIC_W'(938734);
            5'd11:   v = CORDIC_W'(469367);
            5'd12:   v = CORDIC_W'(234684);
            5'd13:   v = CORDIC_W'(117342);
            5'd14:   v = CORDIC_W'(58671);
            5'd15:   v = CORDIC_W'(29335);
            5'd16:   v = CORDIC_W'(14668);
            5'd17:   v = CORDIC_W'(7334);
            5'd18:   v = CORDIC_W'(3667);
            5'd19:   v = CORDIC_W'(1833);
            5'd20:   v = CORDIC_W'(917);
            5'd21:   v = CORDIC_W'(458);
            5'd22:   v = CORDIC_W'(229);
            5'd23:   v = CORDIC_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat_q15(input logic signed [18:0] v);
        logic signed [15:0] r;
        if (v > 19'sd32767) begin
            r = 16'sd32767;
        end else if (v < -19'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mld_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine of an angle in degrees
`default_nettype none

module mld_cordic (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [mld_pkg::YAW_W-1:0]   i_angle,
    output mld_pkg::t_trig                          o_trig
);
    import mld_pkg::*;

    logic                       r_busy;
    logic                       r_done;
    logic                       r_flip;
    logic [ITER_W-1:0]          r_iter;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_z;

    logic signed [CORDIC_W-1:0] w;
    logic signed [CORDIC_W-1:0] load_z;
    logic                       load_flip;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] atan_v;
    logic                       last;

    always_comb begin
        w         = CORDIC_W'(i_angle) <<< (WORK_FRAC - ANGLE_FRACTION_BITS);
        load_z    = w;
        load_flip = 1'b0;
        if (w > CORDIC_QUARTER) begin
            load_z    = w - CORDIC_HALF;
            load_flip = 1'b1;
        end else if (w < -CORDIC_QUARTER) begin
            load_z    = w + CORDIC_HALF;
            load_flip = 1'b1;
        end
        dx     = r_y >>> r_iter;
        dy     = r_x >>> r_iter;
        atan_v = atan_q24(r_iter);
        last   = (r_iter == ITER_W'(TRIG_ITERATIONS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= load_z;
            r_flip <= load_flip;
            r_iter <= '0;
        end else if (r_busy) begin
            if (!r_z[CORDIC_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_v;
            end
            r_iter <= r_iter + 1'b1;
        end
    end

    assign o_trig.done    = r_done;
    assign o_trig.cos_val = r_flip ? -r_x : r_x;
    assign o_trig.sin_val = r_flip ? -r_y : r_y;

endmodule

`default_nettype wire

FILE: rtl/core/mouse_look_direction.sv
// Top level: cursor positions to yaw/pitch to unit look direction in Q1.15
//
//  channel  | signals                              | beat
//  ---------+--------------------------------------+-------------------------------
//  cursor   | i_valid, o_stall, i_data             | cursor_x, cursor_y
//  front    | o_valid, i_stall, o_data             | front_x/y/z, pitch_limited
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_data | sensitivity
//
// One beat runs through two multiplies for the deltas, ten compare-subtract
// steps that wrap yaw, two 16-step passes of the shared CORDIC, and two output multiplies.
// o_stall is high from acceptance until the result is loaded into the output register.
// A new beat is taken while a finished result still waits on a stalled output.
// Reset is synchronous: yaw -90, pitch 45 degrees, sensitivity 0.1, no cursor seen.
`default_nettype none

module mouse_look_direction (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output      logic             o_stall,
    input  wire mld_pkg::t_cursor i_data,
    output      logic             o_valid,
    input  wire logic             i_stall,
    output      mld_pkg::t_front  o_data,
    input  wire logic             i_cfg_valid,
    output      logic             o_cfg_ready,
    input  wire logic [15:0]      i_cfg_data
);
    import mld_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DYAW    = 4'd1;
    localparam logic [3:0] S_DPITCH  = 4'd2;
    localparam logic [3:0] S_PITCH   = 4'd3;
    localparam logic [3:0] S_MOD     = 4'd4;
    localparam logic [3:0] S_CYAW    = 4'd5;
    localparam logic [3:0] S_WYAW    = 4'd6;
    localparam logic [3:0] S_WPITCH  = 4'd7;
    localparam logic [3:0] S_PX      = 4'd8;
    localparam logic [3:0] S_PZ      = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic [15:0]               r_sens;
    logic signed [15:0]        r_prev_x;
    logic signed [15:0]        r_prev_y;
    logic                      r_seen;
    logic signed [YAW_W-1:0]   r_yaw;
    logic signed [PITCH_W-1:0] r_pitch;
    logic                      r_limited;
    logic signed [16:0]        r_dx;
    logic signed [16:0]        r_dy;
    logic signed [63:0]        r_prod;
    logic [MOD_W-1:0]          r_mod;
    logic [MOD_CNT_W-1:0]      r_cnt;
    logic signed [TRIG_W-1:0]  r_cy;
    logic signed [TRIG_W-1:0]  r_sy;
    logic signed [TRIG_W-1:0]  r_cp;
    logic signed [TRIG_W-1:0]  r_sp;
    logic signed [15:0]        r_fx;
    logic                      r_ovalid;
    t_front                    r_out;

    logic                      accept;
    logic                      load_out;
    logic                      mul_en;
    logic signed [31:0]        mul_a;
    logic signed [31:0]        mul_b;
    logic [33:0]               delta_rnd;
    logic signed [DELTA_W-1:0] delta;
    logic [MOD_W-1:0]          mod_sum;
    logic [MOD_W-1:0]          mod_lim;
    logic [MOD_W-1:0]          mod_next;
    logic [MOD_W-1:0]          yaw_u;
    logic signed [DELTA_W:0]   pitch_sum;
    logic signed [63:0]        prod_rnd;
    logic signed [15:0]        prod_q15;
    logic signed [TRIG_W-1:0]  sp_rnd;
    logic signed [15:0]        sp_q15;
    logic                      trig_start;
    logic signed [YAW_W-1:0]   trig_angle;
    t_trig                     trig;

    mld_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (trig_start),
        .i_angle (trig_angle),
        .o_trig  (trig)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !o_stall;
    assign load_out    = (r_state == S_DONE) && (!r_ovalid || !i_stall);
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;

    assign trig_start = (r_state == S_CYAW) || ((r_state == S_WYAW) && trig.done);
    assign trig_angle = (r_state == S_CYAW) ? r_yaw : YAW_W'(r_pitch);

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_DYAW: begin
                mul_a = 32'(r_dx);
                mul_b = {16'd0, r_sens};
            end
            S_DPITCH: begin
                mul_a = 32'(r_dy);
                mul_b = {16'd0, r_sens};
            end
            S_PX: begin
                mul_a = r_cy;
                mul_b = r_cp;
            end
            S_PZ: begin
                mul_a = r_sy;
                mul_b = r_cp;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        delta_rnd = r_prod[33:0] + 34'(1 << (DELTA_SHIFT - 1));
        delta     = delta_rnd[33:DELTA_SHIFT];
        mod_sum   = MOD_W'(r_yaw) + MOD_W'(delta) + ANGLE_HALF + ANGLE_OFFSET;
        mod_lim   = ANGLE_FULL << r_cnt;
        mod_next  = (r_mod >= mod_lim) ? (r_mod - mod_lim) : r_mod;
        yaw_u     = mod_next - ANGLE_HALF;
        pitch_sum = (DELTA_W + 1)'(r_pitch) + (DELTA_W + 1)'(delta);
        prod_rnd  = r_prod + (64'sd1 <<< 44);
        prod_q15  = sat_q15(prod_rnd[63:45]);
        sp_rnd    = r_sp + 32'sd16384;
        sp_q15    = sat_q15(19'(sp_rnd >>> 15));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (accept) n_state = S_DYAW;
            S_DYAW:   n_state = S_DPITCH;
            S_DPITCH: n_state = S_PITCH;
            S_PITCH:  n_state = S_MOD;
            S_MOD:    if (r_cnt == '0) n_state = S_CYAW;
            S_CYAW:   n_state = S_WYAW;
            S_WYAW:   if (trig.done) n_state = S_WPITCH;
            S_WPITCH: if (trig.done) n_state = S_PX;
            S_PX:     n_state = S_PZ;
            S_PZ:     n_state = S_DONE;
            S_DONE:   if (load_out) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sens    <= SENS_RESET;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_seen    <= 1'b0;
            r_yaw     <= YAW_RESET;
            r_pitch   <= PITCH_RESET;
            r_limited <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_sens <= i_cfg_data;
            end
            if (accept) begin
                r_prev_x <= i_data.cursor_x;
                r_prev_y <= i_data.cursor_y;
                r_seen   <= 1'b1;
            end
            if (r_state == S_PITCH) begin
                if (pitch_sum > (DELTA_W + 1)'(PITCH_LIMIT)) begin
                    r_pitch   <= PITCH_LIMIT;
                    r_limited <= 1'b1;
                end else if (pitch_sum < -((DELTA_W + 1)'(PITCH_LIMIT))) begin
                    r_pitch   <= -PITCH_LIMIT;
                    r_limited <= 1'b1;
                end else begin
                    r_pitch   <= pitch_sum[PITCH_W-1:0];
                    r_limited <= 1'b0;
                end
            end
            if ((r_state == S_MOD) && (r_cnt == '0)) begin
                r_yaw <= yaw_u[YAW_W-1:0];
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_seen) begin
                r_dx <= 17'(i_data.cursor_x) - 17'(r_prev_x);
                r_dy <= 17'(r_prev_y) - 17'(i_data.cursor_y);
            end else begin
                r_dx <= '0;
                r_dy <= '0;
            end
        end
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == S_DPITCH) begin
            r_mod <= mod_sum;
        end
        if (r_state == S_PITCH) begin
            r_cnt <= MOD_CNT_W'(MOD_STEPS - 1);
        end else if (r_state == S_MOD) begin
            r_mod <= mod_next;
            r_cnt <= r_cnt - 1'b1;
        end
        if ((r_state == S_WYAW) && trig.done) begin
            r_cy <= TRIG_W'(trig.cos_val);
            r_sy <= TRIG_W'(trig.sin_val);
        end
        if ((r_state == S_WPITCH) && trig.done) begin
            r_cp <= TRIG_W'(trig.cos_val);
            r_sp <= TRIG_W'(trig.sin_val);
        end
        if (r_state == S_PZ) begin
            r_fx <= prod_q15;
        end
        if (load_out) begin
            r_out.front_x       <= r_fx;
            r_out.front_y       <= sp_q15;
            r_out.front_z       <= prod_q15;
            r_out.pitch_limited <= r_limited;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mld_checker.sv
// Port checker for the mouse look direction block and its bind
`default_nettype none

module mld_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             o_stall,
    input wire logic             o_valid,
    input wire logic             i_stall,
    input wire mld_pkg::t_front  o_data
);
    import mld_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted while block stayed ready");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset did not clear handshake state");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result beat without work in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result beat changed");

    a_limited_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.pitch_limited |->
            (o_data.front_y > 16'sd32000 || o_data.front_y < -16'sd32000))
        else $error("limited pitch with small vertical component");

endmodule

bind mouse_look_direction mld_checker u_mld_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire

FILE: tb/testbench.sv
// Testbench: directed and random cursor beats checked against a fixed-point look-direction predictor
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mld_pkg::*;

    localparam int     CYCLE_LIMIT   = 500000;
    localparam int     SETTLE_CYCLES = 80;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     HOLD_AT_BEAT  = 160;
    localparam int     REPORT_LIMIT  = 10;
    localparam int     RANDOM_PHASES = 6;
    localparam int     PHASE_BEATS   = 100;
    localparam int     STEP_SHIFT    = 16 - ANGLE_FRACTION_BITS;
    localparam longint TURN_FULL     = longint'(360) <<< ANGLE_FRACTION_BITS;
    localparam longint TURN_HALF     = longint'(180) <<< ANGLE_FRACTION_BITS;
    localparam longint TILT_LIMIT    = longint'(89) <<< ANGLE_FRACTION_BITS;
    localparam longint FOLD_QUARTER  = longint'(90) <<< WORK_FRAC;
    localparam longint FOLD_HALF     = longint'(180) <<< WORK_FRAC;
    localparam longint CORDIC_START  = 652032875;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_cursor     i_data      = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_front      o_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data  = '0;

    t_cursor cursor_pending[$];
    t_front  front_expected[$];

    int cycle_count = 0;
    int fault_count = 0;
    int fronts_seen = 0;
    int send_gap    = 0;
    int stall_left  = 0;
    bit hold_done   = 1'b0;
    bit quiet       = 1'b0;

    longint sens_q16    = 6554;
    longint last_x      = 0;
    longint last_y      = 0;
    bit     cursor_seen = 1'b0;
    longint yaw_fx      = -(longint'(90) <<< ANGLE_FRACTION_BITS);
    longint pitch_fx    = longint'(45) <<< ANGLE_FRACTION_BITS;

    mouse_look_direction dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint arc_deg_q24(input int i);
        case (i)
            0:       return 754974720;
            1:       return 445687602;
            2:       return 235489089;
            3:       return 119537938;
            4:       return 60000934;
            5:       return 30029717;
            6:       return 15018523;
            7:       return 7509720;
            8:       return 3754917;
            9:       return 1877466;
            10:      return 938734;
            11:      return 469367;
            12:      return 234684;
            13:      return 117342;
            14:      return 58671;
            15:      return 29335;
            16:      return 14668;
            17:      return 7334;
            18:      return 3667;
            19:      return 1833;
            20:      return 917;
            21:      return 458;
            22:      return 229;
            23:      return 115;
            default: return 0;
        endcase
    endfunction

    function automatic longint round_up_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] q15_of(input longint v, input int s);
        longint r;
        r = round_up_shift(v, s);
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    function automatic void sin_cos_deg(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit     flip;
        z    = ang <<< (WORK_FRAC - ANGLE_FRACTION_BITS);
        flip = 1'b0;
        if (z > FOLD_QUARTER) begin
            z    = z - FOLD_HALF;
            flip = 1'b1;
        end else if (z < -FOLD_QUARTER) begin
            z    = z + FOLD_HALF;
            flip = 1'b1;
        end
        x = CORDIC_START;
        y = 0;
        for (int i = 0; i < TRIG_ITERATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arc_deg_q24(i);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arc_deg_q24(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic t_front look_step(input t_cursor beat);
        longint cx, cy, dyaw, dpitch, cos_yaw, sin_yaw, cos_pitch, sin_pitch;
        t_front f;
        cx = $signed(beat.cursor_x);
        cy = $signed(beat.cursor_y);
        if (!cursor_seen) begin
            last_x      = cx;
            last_y      = cy;
            cursor_seen = 1'b1;
        end
        dyaw   = round_up_shift((cx - last_x) * sens_q16, STEP_SHIFT);
        dpitch = round_up_shift((last_y - cy) * sens_q16, STEP_SHIFT);
        last_x = cx;
        last_y = cy;

        yaw_fx = (yaw_fx + dyaw + TURN_HALF) % TURN_FULL;
        if (yaw_fx < 0) begin
            yaw_fx = yaw_fx + TURN_FULL;
        end
        yaw_fx = yaw_fx - TURN_HALF;

        f.pitch_limited = 1'b0;
        pitch_fx = pitch_fx + dpitch;
        if (pitch_fx > TILT_LIMIT) begin
            pitch_fx        = TILT_LIMIT;
            f.pitch_limited = 1'b1;
        end else if (pitch_fx < -TILT_LIMIT) begin
            pitch_fx        = -TILT_LIMIT;
            f.pitch_limited = 1'b1;
        end

        sin_cos_deg(yaw_fx, cos_yaw, sin_yaw);
        sin_cos_deg(pitch_fx, cos_pitch, sin_pitch);
        f.front_x = q15_of(cos_yaw * cos_pitch, 45);
        f.front_y = q15_of(sin_pitch, 15);
        f.front_z = q15_of(sin_yaw * cos_pitch, 45);
        return f;
    endfunction

    function automatic int clip16(input int v);
        if (v > 32767) begin
            return 32767;
        end else if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic void push_cursor(input int x, input int y);
        t_cursor c;
        c.cursor_x = x[15:0];
        c.cursor_y = y[15:0];
        cursor_pending.push_back(c);
    endfunction

    task automatic wait_drained();
        while (cursor_pending.size() != 0 || i_valid || front_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sensitivity(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sens_q16     = v;
        i_cfg_valid <= 1'b0;
    endtask

    // cursor driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                front_expected.push_back(look_step(i_data));
            end
            if (!i_valid || !o_stall) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(0, 14);
                    i_valid  <= 1'b0;
                end else if (cursor_pending.size() != 0) begin
                    i_valid <= 1'b1;
                    i_data  <= cursor_pending.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result stall: random bursts, plus one long hold to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (!hold_done && fronts_seen >= HOLD_AT_BEAT) begin
            hold_done  <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
            i_stall    <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // front monitor
    always @(posedge i_clk) begin
        t_front want;
        if (i_rst_n && o_valid && !i_stall) begin
            fronts_seen <= fronts_seen + 1;
            if (front_expected.size() == 0) begin
                fault_count = fault_count + 1;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("unexpected front beat: x=%0d y=%0d z=%0d limited=%0b",
                             o_data.front_x, o_data.front_y, o_data.front_z,
                             o_data.pitch_limited);
                end
            end else begin
                want = front_expected.pop_front();
                if (o_data.front_x !== want.front_x || o_data.front_y !== want.front_y ||
                    o_data.front_z !== want.front_z ||
                    o_data.pitch_limited !== want.pitch_limited) begin
                    fault_count = fault_count + 1;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("front mismatch at beat %0d: expected x=%0d y=%0d z=%0d lim=%0b",
                                 fronts_seen, want.front_x, want.front_y, want.front_z,
                                 want.pitch_limited);
                        $display("                       got      x=%0d y=%0d z=%0d lim=%0b",
                                 o_data.front_x, o_data.front_y, o_data.front_z,
                                 o_data.pitch_limited);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int          walk_x, walk_y, pick;
        logic [15:0] level;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sensitivity; first beat has no previous position
        push_cursor(100, -50);
        push_cursor(32767, 32767);
        push_cursor(-32768, -32768);
        push_cursor(0, 0);
        push_cursor(-1, 1);
        wait_drained();

        // full scale: yaw wraps many turns per beat
        write_sensitivity(16'hFFFF);
        push_cursor(-32768, 0);
        push_cursor(32767, 0);
        push_cursor(-32768, 32767);
        push_cursor(32767, -32768);
        wait_drained();

        // one pixel per 1/256 degree: land pitch on the limits exactly
        write_sensitivity(16'd256);
        push_cursor(0, 0);
        push_cursor(0, -30000);
        push_cursor(0, -30000);
        push_cursor(0, 15568);
        push_cursor(23040, 15568);
        push_cursor(-23040, 20000);
        wait_drained();

        write_sensitivity(16'd0);
        push_cursor(12345, -321);
        push_cursor(-32768, 32767);
        wait_drained();

        write_sensitivity(16'd1);
        push_cursor(32767, -32768);
        push_cursor(-32768, 32767);
        wait_drained();

        walk_x = -32768;
        walk_y = 32767;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 3)
                0:       level = 16'($urandom_range(1, 1024));
                1:       level = 16'($urandom_range(0, 65535));
                default: level = 16'($urandom_range(1024, 16384));
            endcase
            write_sensitivity(level);
            quiet = (phase == RANDOM_PHASES - 1);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                pick = $urandom_range(0, 19);
                if (pick < 2) begin
                    walk_x = int'($urandom_range(0, 65535)) - 32768;
                    walk_y = int'($urandom_range(0, 65535)) - 32768;
                end else if (pick > 2) begin
                    walk_x = clip16(walk_x + int'($urandom_range(0, 400)) - 200);
                    walk_y = clip16(walk_y + int'($urandom_range(0, 400)) - 200);
                end
                push_cursor(walk_x, walk_y);
            end
            wait_drained();
        end

        if (fault_count == 0 && front_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
